/* sv/splr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// splr_pkg
// Shared widths, register map and reset values of the spectrum resampler.
// ----------------------------------------------------------------------------
package splr_pkg;

    localparam int WL_W     = 12;
    localparam int IRR_W    = 32;
    localparam int STEP_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int X_W      = 15;
    localparam int NUM_W    = 48;
    localparam int DIV_BITS = 4;

    localparam int MAX_RESULTS = 64;

    localparam logic [WL_W-1:0]    GRID_START_RST = 12'd405;
    localparam logic [STEP_W-1:0]  GRID_STEP_RST  = 8'd5;
    localparam logic [COUNT_W-1:0] GRID_COUNT_RST = 7'd61;

    typedef enum logic [1:0] {
        REG_GRID_START = 2'd0,
        REG_GRID_STEP  = 2'd1,
        REG_GRID_COUNT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [WL_W-1:0]   divisor;
    } div_req_t;

endpackage
`default_nettype wire

/* sv/splr_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// splr_div
// Restoring unsigned divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module splr_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire splr_pkg::div_req_t           req,
    output logic                              done,
    output logic [splr_pkg::NUM_W-1:0]        quotient
);

    localparam int STEPS = splr_pkg::NUM_W / splr_pkg::DIV_BITS;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int RW    = splr_pkg::WL_W + 1;

    logic                         busy_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         done_reg;
    logic [splr_pkg::NUM_W-1:0]   quo_reg, quo_next;
    logic [RW-1:0]                rem_reg, rem_next;
    logic [splr_pkg::WL_W-1:0]    dvs_reg;

    always_comb begin
        logic [RW-1:0]              r;
        logic [splr_pkg::NUM_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < splr_pkg::DIV_BITS; i++) begin
            r = {r[RW-2:0], q[splr_pkg::NUM_W-1]};
            q = {q[splr_pkg::NUM_W-2:0], 1'b0};
            if (r >= {1'b0, dvs_reg}) begin
                r    = r - {1'b0, dvs_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(STEPS);
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

/* sv/spectrum_linear_resampler_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_linear_resampler_top
// Loads (wavelength, irradiance) pairs and emits a linearly resampled grid.
// ----------------------------------------------------------------------------
// Pairs are taken one word per cycle into two dual-read memories until a word
// with tlast arrives; the input then stalls while grid_count results are sent.
// Result 0 is read and sent without interpolation. Each interpolated result takes a
// read and compare per segment advance of the walk, then read, multiply, radix-16
// divider and output load; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module spectrum_linear_resampler_top #(
    parameter int MAX_POINTS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // fields: wavelength_nm[11:0], irradiance_in[43:12], zero fill
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tlast,
    output logic             s_tready,
    // fields: sample_index[5:0], irradiance_out[37:6], zero fill
    output logic [39:0]      m_tdata,
    output logic             m_tvalid,
    output logic             m_tlast,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDXW = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int WL_W = splr_pkg::WL_W;
    localparam int IR_W = splr_pkg::IRR_W;
    localparam int X_W  = splr_pkg::X_W;
    localparam int NW   = splr_pkg::NUM_W;

    typedef enum logic [2:0] {
        S_LOAD, S_RD, S_EV, S_MUL, S_PREP, S_DIV, S_OUT
    } state_t;

    state_t                      state_reg;
    logic [WL_W-1:0]             start_reg;
    logic [splr_pkg::STEP_W-1:0] step_reg;
    logic [splr_pkg::COUNT_W-1:0] count_reg;

    logic [CNTW-1:0]             cnt_reg, n_reg;
    logic [IDXW-1:0]             seg_reg;
    logic [splr_pkg::INDEX_W-1:0] k_reg;
    logic [splr_pkg::COUNT_W-1:0] total_reg;
    logic [X_W-1:0]              x_reg;

    logic [WL_W-1:0]             wl_mem [MAX_POINTS];
    logic [IR_W-1:0]             ir_mem [MAX_POINTS];
    logic [WL_W-1:0]             wa_reg, wb_reg;
    logic [IR_W-1:0]             ya_reg, yb_reg;

    logic [WL_W-1:0]             den_reg;
    logic signed [IR_W:0]        diff_reg;
    logic signed [15:0]          dx_reg;
    logic signed [48:0]          prod_reg;
    logic                        neg_reg;
    logic [IR_W-1:0]             res_reg;

    logic [splr_pkg::INDEX_W-1:0] m_idx_reg;
    logic [IR_W-1:0]             m_irr_reg;
    logic                        m_valid_reg, m_last_reg;

    splr_pkg::div_req_t          div_req;
    logic                        div_done;
    logic [NW-1:0]               div_q;

    logic                        s_acc, cfg_wr, use_first, walk, out_free, k_last;
    logic                        out_load;
    logic [IDXW-1:0]             addr_a, addr_b;
    logic [CNTW-1:0]             n_next;
    logic [NW-1:0]               mag;
    logic signed [NW+1:0]        r_sum;
    logic [IR_W-1:0]             r_sat;
    logic [splr_pkg::COUNT_W-1:0] total_next;

    assign s_tready = (state_reg == S_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            splr_pkg::REG_GRID_START: prdata = {20'd0, start_reg};
            splr_pkg::REG_GRID_STEP:  prdata = {24'd0, step_reg};
            splr_pkg::REG_GRID_COUNT: prdata = {25'd0, count_reg};
            default:                  prdata = '0;
        endcase
    end

    assign n_next     = (cnt_reg < CNTW'(MAX_POINTS)) ? cnt_reg + 1'b1 : cnt_reg;
    assign total_next = (count_reg == '0) ? splr_pkg::COUNT_W'(1) :
                        (count_reg > splr_pkg::COUNT_W'(splr_pkg::MAX_RESULTS)) ?
                        splr_pkg::COUNT_W'(splr_pkg::MAX_RESULTS) : count_reg;
    assign use_first  = (k_reg == '0) || (n_reg < CNTW'(2));
    assign addr_a     = use_first ? '0 : seg_reg;
    assign addr_b     = seg_reg + 1'b1;
    assign walk       = ((CNTW+1)'(seg_reg) + (CNTW+1)'(2) < (CNTW+1)'(n_reg)) &&
                        (x_reg >= X_W'(wb_reg));
    assign out_free   = !m_valid_reg || m_tready;
    assign out_load   = (state_reg == S_OUT) && out_free;
    assign k_last     = ({1'b0, k_reg} == total_reg - 1'b1);
    assign mag        = prod_reg[48] ? NW'(-prod_reg) : NW'(prod_reg);

    assign div_req.start    = (state_reg == S_PREP);
    assign div_req.dividend = mag + NW'(den_reg >> 1);
    assign div_req.divisor  = den_reg;

    assign r_sum = neg_reg ? $signed({18'd0, ya_reg}) - $signed({2'b00, div_q})
                           : $signed({18'd0, ya_reg}) + $signed({2'b00, div_q});
    assign r_sat = r_sum[NW+1] ? '0 : (|r_sum[NW:IR_W]) ? '1 : r_sum[IR_W-1:0];

    splr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (s_acc && (cnt_reg < CNTW'(MAX_POINTS))) begin
            wl_mem[cnt_reg[IDXW-1:0]] <= s_tdata[11:0];
            ir_mem[cnt_reg[IDXW-1:0]] <= s_tdata[43:12];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RD) begin
            wa_reg <= wl_mem[addr_a];
            wb_reg <= wl_mem[addr_b];
            ya_reg <= ir_mem[addr_a];
            yb_reg <= ir_mem[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= splr_pkg::GRID_START_RST;
            step_reg  <= splr_pkg::GRID_STEP_RST;
            count_reg <= splr_pkg::GRID_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                splr_pkg::REG_GRID_START: start_reg <= pwdata[WL_W-1:0];
                splr_pkg::REG_GRID_STEP:  step_reg  <= pwdata[splr_pkg::STEP_W-1:0];
                splr_pkg::REG_GRID_COUNT: count_reg <= pwdata[splr_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (s_acc) begin
                        if (s_tlast) begin
                            cnt_reg   <= '0;
                            n_reg     <= n_next;
                            seg_reg   <= (n_next >= CNTW'(3)) ? IDXW'(1) : '0;
                            k_reg     <= '0;
                            x_reg     <= X_W'(start_reg);
                            total_reg <= total_next;
                            state_reg <= S_RD;
                        end else begin
                            cnt_reg <= n_next;
                        end
                    end
                end
                S_RD: state_reg <= S_EV;
                S_EV: begin
                    if (use_first) begin
                        res_reg   <= ya_reg;
                        state_reg <= S_OUT;
                    end else if (walk) begin
                        seg_reg   <= seg_reg + 1'b1;
                        state_reg <= S_RD;
                    end else if (wb_reg <= wa_reg) begin
                        res_reg   <= ya_reg;
                        state_reg <= S_OUT;
                    end else begin
                        den_reg   <= wb_reg - wa_reg;
                        diff_reg  <= $signed({1'b0, yb_reg}) - $signed({1'b0, ya_reg});
                        dx_reg    <= $signed({1'b0, x_reg}) - $signed({4'd0, wa_reg});
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= diff_reg * dx_reg;
                    state_reg <= S_PREP;
                end
                S_PREP: begin
                    neg_reg   <= prod_reg[48];
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        res_reg   <= r_sat;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_idx_reg   <= k_reg;
                        m_irr_reg   <= res_reg;
                        m_last_reg  <= k_last;
                        if (k_last) begin
                            state_reg <= S_LOAD;
                        end else begin
                            if (k_reg != '0) begin
                                x_reg <= x_reg + X_W'(step_reg);
                            end
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_irr_reg, m_idx_reg};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNTW'(MAX_POINTS))
        else $error("fill count beyond store depth");

    a_seg_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_LOAD) && (n_reg >= CNTW'(2)) |->
        ((CNTW+1)'(seg_reg) + (CNTW+1)'(1) < (CNTW+1)'(n_reg)))
        else $error("segment pointer past loaded pairs");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside of divide state");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |=> !s_tready)
        else $error("input accepted during burst");

endmodule
`default_nettype wire
